// ===== design/assert_macros.svh =====
// Assertion macros used by periodic_alarm_table_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/pat_pkg.sv =====
// ----------------------------------------------------------------------------
// pat_pkg
// Types and constants of the periodic alarm table.
// ----------------------------------------------------------------------------
package pat_pkg;

  localparam int SLOTS_DEFAULT = 32;

  localparam int DUE_W = 48;
  localparam logic [DUE_W-1:0] DUE_MAX = {DUE_W{1'b1}};

  // One day is 675 units of 128 seconds.
  localparam int DAY_SHIFT   = 7;
  localparam int DAY_UNITS   = 675;
  localparam int RECIP_SHIFT = 35;
  localparam logic [25:0] DAY_RECIP = 26'((64'd1 << RECIP_SHIFT) / DAY_UNITS);

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] RK_FIRED = 2'd0;
  localparam logic [1:0] RK_TICK  = 2'd1;
  localparam logic [1:0] RK_REPLY = 2'd2;

  localparam logic [7:0] KIND_FIRING = 8'd1;

  typedef struct packed {
    logic             valid;
    logic [DUE_W-1:0] due;
    logic [15:0]      reps;
    logic [31:0]      period;
    logic [7:0]       tag;
    logic [7:0]       kind;
  } pat_rec_t;

  typedef struct packed {
    logic fire;
    logic take;
    logic freed;
  } pat_stat_t;

endpackage

// ===== design/pat_if.sv =====
// ----------------------------------------------------------------------------
// pat_cmd_if / pat_res_if
// Valid/ready channels for commands and results of the alarm table.
// ----------------------------------------------------------------------------
interface pat_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] now;
  logic [16:0] offset_in_day;
  logic [7:0]  alarm_kind;
  logic [15:0] repeat_count;
  logic [31:0] period;
  logic [7:0]  tag;

  modport source (output valid, cmd, now, offset_in_day, alarm_kind, repeat_count,
                  period, tag, input ready);
  modport sink (input valid, cmd, now, offset_in_day, alarm_kind, repeat_count,
                period, tag, output ready);
endinterface

interface pat_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [4:0]  slot;
  logic [7:0]  fired_tag;
  logic [5:0]  total;
  logic        ok;
  logic        last;

  modport source (output valid, result_kind, slot, fired_tag, total, ok, last,
                  input ready);
  modport sink (input valid, result_kind, slot, fired_tag, total, ok, last,
                output ready);
endinterface

// ===== design/pat_cell.sv =====
// ----------------------------------------------------------------------------
// pat_cell
// One slot record of the rotating table; loads its neighbor's record on shift.
// ----------------------------------------------------------------------------
module pat_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  pat_pkg::pat_rec_t rec_in,
  output pat_pkg::pat_rec_t rec
);
  import pat_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec.valid <= 1'b0;
    end else if (shift) begin
      rec <= rec_in;
    end
  end

endmodule

// ===== design/pat_proc.sv =====
// ----------------------------------------------------------------------------
// pat_proc
// Update logic applied to the record leaving the head of the ring.
// ----------------------------------------------------------------------------
module pat_proc (
  input  logic [1:0]         op,
  input  logic [31:0]        now,
  input  logic [7:0]         tag,
  input  logic               found,
  input  pat_pkg::pat_rec_t  new_rec,
  input  pat_pkg::pat_rec_t  head,
  output pat_pkg::pat_rec_t  rec_out,
  output pat_pkg::pat_stat_t stat
);
  import pat_pkg::*;

  logic [DUE_W:0] sum;

  assign sum = {1'b0, head.due} + {{(DUE_W-31){1'b0}}, head.period};

  always_comb begin
    stat.fire  = (op == CMD_TICK) && head.valid && (head.kind == KIND_FIRING) &&
                 (head.reps != 16'd0) && ({16'd0, now} > head.due);
    stat.take  = (op == CMD_ADD) && !found && !head.valid;
    stat.freed = (op == CMD_CLEAR) && head.valid && (head.tag == tag);
    rec_out = head;
    if (stat.fire) begin
      rec_out.reps = head.reps - 16'd1;
      rec_out.due  = sum[DUE_W] ? DUE_MAX : sum[DUE_W-1:0];
    end
    if (stat.take) begin
      rec_out = new_rec;
    end
    if (stat.freed) begin
      rec_out.valid = 1'b0;
    end
  end

endmodule

// ===== design/periodic_alarm_table_unit.sv =====
// ----------------------------------------------------------------------------
// periodic_alarm_table_unit
// Table of repeating alarms held in a rotating chain of slot cells.
// ----------------------------------------------------------------------------
// The alarm records live in a ring of SLOTS cells that rotates by one place per
// cycle while a command is being worked on, except while a fired result waits
// for the output register. Each record passes the update logic at the head of
// the ring once per command, so every command takes one full revolution; an add
// first passes S_DIV1 and S_DIV2, which round the time down to a whole day. A
// tick gives one fired transaction per alarm that fires, in slot order, then a
// tick-finished transaction; an add or a clear gives one reply. Commands are
// taken one at a time. A command with the unused code 3 is accepted and dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module periodic_alarm_table_unit #(
  parameter int SLOTS = pat_pkg::SLOTS_DEFAULT
) (
  input logic clk,
  input logic rst,
  pat_cmd_if.sink   requests,
  pat_res_if.source results
);
  import pat_pkg::*;

  localparam int IDXW = $clog2(SLOTS);
  localparam int CNTW = $clog2(SLOTS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV1 = 5'b00010,
    S_DIV2 = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;

  // Latched command.
  logic [1:0]  op;
  logic [31:0] now_q;
  logic [16:0] offs_q;
  logic [7:0]  kind_q;
  logic [15:0] reps_q;
  logic [31:0] per_q;
  logic [7:0]  tag_q;

  // Day rounding: the time in 128 s units is divided by 675 through a
  // reciprocal multiply and one correction step.
  logic [50:0] prod;
  logic [31:0] base;
  logic [15:0] quo;
  logic [25:0] day_units;
  logic [25:0] rem;
  logic [25:0] floor_units;

  // Scan bookkeeping.
  logic [IDXW-1:0] cnt;
  logic [CNTW-1:0] n;
  logic            found;
  logic [IDXW-1:0] found_idx;

  pat_rec_t  recs [SLOTS];
  pat_rec_t  proc_out;
  pat_rec_t  new_rec;
  pat_stat_t stat;
  logic      shift;

  // Output register.
  logic       out_valid;
  logic [1:0] out_kind;
  logic [4:0] out_slot;
  logic [7:0] out_tag;
  logic [5:0] out_total;
  logic       out_ok;
  logic       out_last;
  logic       can_load;

  logic [IDXW+4:0] cnt_ext;
  logic [IDXW+4:0] found_ext;
  logic [CNTW+5:0] n_ext;

  assign quo         = prod[50:RECIP_SHIFT];
  assign day_units   = 26'({10'd0, quo} * 10'(DAY_UNITS));
  assign rem         = {1'b0, now_q[31:DAY_SHIFT]} - day_units;
  assign floor_units = (rem >= 26'(DAY_UNITS)) ? day_units + 26'(DAY_UNITS) : day_units;

  assign new_rec.valid  = 1'b1;
  assign new_rec.due    = {16'd0, base} + {31'd0, offs_q};
  assign new_rec.reps   = reps_q;
  assign new_rec.period = per_q;
  assign new_rec.tag    = tag_q;
  assign new_rec.kind   = kind_q;

  assign can_load = !out_valid || results.ready;
  // The ring holds still while a fired result waits for the output register.
  assign shift    = (state == S_SCAN) && (!stat.fire || can_load);

  assign requests.ready = (state == S_IDLE);

  pat_proc u_proc (
    .op      (op),
    .now     (now_q),
    .tag     (tag_q),
    .found   (found),
    .new_rec (new_rec),
    .head    (recs[0]),
    .rec_out (proc_out),
    .stat    (stat)
  );

  // The record at the head is updated and re-enters at the tail, so after one
  // revolution every slot is back in its own cell.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      pat_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .rec_in(proc_out),
                       .rec(recs[i]));
    end else begin : g_body
      pat_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .rec_in(recs[i+1]),
                       .rec(recs[i]));
    end
  end

  assign cnt_ext   = {5'd0, cnt};
  assign found_ext = {5'd0, found_idx};
  assign n_ext     = {6'd0, n};

  always_ff @(posedge clk) begin
    if (requests.valid && requests.ready) begin
      op     <= requests.cmd;
      now_q  <= requests.now;
      offs_q <= requests.offset_in_day;
      kind_q <= requests.alarm_kind;
      reps_q <= requests.repeat_count;
      per_q  <= requests.period;
      tag_q  <= requests.tag;
    end
    if (state == S_DIV1) begin
      prod <= {1'b0, now_q[31:DAY_SHIFT]} * DAY_RECIP;
    end
    if (state == S_DIV2) begin
      base <= {floor_units[24:0], {DAY_SHIFT{1'b0}}};
    end
    if (shift && stat.take) begin
      found_idx <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      n         <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          cnt   <= '0;
          n     <= '0;
          found <= 1'b0;
          if (requests.valid) begin
            case (requests.cmd)
              CMD_TICK:  state <= S_SCAN;
              CMD_ADD:   state <= S_DIV1;
              CMD_CLEAR: state <= S_SCAN;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_DIV1: state <= S_DIV2;
        S_DIV2: state <= S_SCAN;
        S_SCAN: begin
          if (shift) begin
            cnt <= cnt + 1'b1;
            if (stat.fire || stat.freed) begin
              n <= n + 1'b1;
            end
            if (stat.take) begin
              found <= 1'b1;
            end
            if (cnt == IDXW'(SLOTS - 1)) begin
              state <= S_DONE;
            end
          end
          if (stat.fire && can_load) begin
            out_valid <= 1'b1;
            out_kind  <= RK_FIRED;
            out_slot  <= cnt_ext[4:0];
            out_tag   <= recs[0].tag;
            out_total <= 6'd0;
            out_ok    <= 1'b0;
            out_last  <= 1'b0;
          end
        end
        S_DONE: begin
          if (can_load) begin
            out_valid <= 1'b1;
            out_tag   <= 8'd0;
            out_last  <= 1'b1;
            out_total <= (op == CMD_ADD) ? 6'd0 : n_ext[5:0];
            out_kind  <= (op == CMD_TICK) ? RK_TICK : RK_REPLY;
            out_ok    <= (op == CMD_ADD) && found;
            out_slot  <= ((op == CMD_ADD) && found) ? found_ext[4:0] : 5'd0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid       = out_valid;
  assign results.result_kind = out_kind;
  assign results.slot        = out_slot;
  assign results.fired_tag   = out_tag;
  assign results.total       = out_total;
  assign results.ok          = out_ok;
  assign results.last        = out_last;

  `ASSERT_IMPLIES(a_count_bound, state == S_SCAN, n <= CNTW'(SLOTS))
  `ASSERT_NEXT(a_done_to_idle, (state == S_DONE) && can_load, state == S_IDLE)
  `ASSERT_IMPLIES(a_only_one_action, state == S_SCAN, $onehot0(stat))
  `ASSERT_NEXT(a_fire_loads, (state == S_SCAN) && stat.fire && can_load, out_valid)

endmodule

// ===== tb/pat_alarm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pat_alarm_checker
// Watches both channels of the alarm table, keeps a shadow table, predicts
// every result transaction and compares it field by field.
// ----------------------------------------------------------------------------
module pat_alarm_checker (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  logic cmd_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] now,
  input  logic [16:0] offset_in_day,
  input  logic [7:0]  alarm_kind,
  input  logic [15:0] repeat_count,
  input  logic [31:0] period,
  input  logic [7:0]  tag,
  input  logic res_valid,
  input  logic res_ready,
  input  logic [1:0]  result_kind,
  input  logic [4:0]  slot,
  input  logic [7:0]  fired_tag,
  input  logic [5:0]  total,
  input  logic        ok,
  input  logic        last,
  output int          fail_count,
  output int          pending
);
  import pat_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] slot;
    logic [7:0] tag;
    logic [5:0] total;
    logic       ok;
    logic       last;
  } alarm_result_t;

  localparam int NSLOT = 32;
  localparam logic [47:0] DAY_SEC = 48'd86400;

  logic        sh_valid [NSLOT];
  logic [47:0] sh_due   [NSLOT];
  logic [15:0] sh_reps  [NSLOT];
  logic [31:0] sh_per   [NSLOT];
  logic [7:0]  sh_tag   [NSLOT];
  logic [7:0]  sh_kind  [NSLOT];

  alarm_result_t expected_results[$];

  function automatic alarm_result_t mk(logic [1:0] k, logic [4:0] s, logic [7:0] t,
                                       logic [5:0] n, logic o, logic l);
    mk = '{kind: k, slot: s, tag: t, total: n, ok: o, last: l};
  endfunction

  task automatic apply_command();
    int n;
    logic [48:0] sum;
    logic found;
    n = 0;
    found = 1'b0;
    if (cmd == CMD_TICK) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (sh_valid[i] && sh_kind[i] == KIND_FIRING && sh_reps[i] != 0 &&
            {16'd0, now} > sh_due[i]) begin
          sum = {1'b0, sh_due[i]} + {17'd0, sh_per[i]};
          sh_reps[i] = sh_reps[i] - 16'd1;
          sh_due[i] = sum[48] ? DUE_MAX : sum[47:0];
          expected_results.push_back(mk(RK_FIRED, 5'(i), sh_tag[i], 6'd0, 1'b0, 1'b0));
          n++;
        end
      end
      expected_results.push_back(mk(RK_TICK, 5'd0, 8'd0, 6'(n), 1'b0, 1'b1));
    end else if (cmd == CMD_ADD) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (!found && !sh_valid[i]) begin
          found = 1'b1;
          sh_valid[i] = 1'b1;
          sh_due[i] = {31'd0, offset_in_day} + ({16'd0, now} / DAY_SEC) * DAY_SEC;
          sh_reps[i] = repeat_count;
          sh_per[i] = period;
          sh_tag[i] = tag;
          sh_kind[i] = alarm_kind;
          expected_results.push_back(mk(RK_REPLY, 5'(i), 8'd0, 6'd0, 1'b1, 1'b1));
        end
      end
      if (!found) expected_results.push_back(mk(RK_REPLY, 5'd0, 8'd0, 6'd0, 1'b0, 1'b1));
    end else if (cmd == CMD_CLEAR) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (sh_valid[i] && sh_tag[i] == tag) begin
          sh_valid[i] = 1'b0;
          n++;
        end
      end
      expected_results.push_back(mk(RK_REPLY, 5'd0, 8'd0, 6'(n), 1'b0, 1'b1));
    end
  endtask

  always @(posedge clk) begin
    alarm_result_t got, want;
    if (rst) begin
      for (int i = 0; i < NSLOT; i++) sh_valid[i] = 1'b0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (cmd_valid && cmd_ready) apply_command();
      if (res_valid && res_ready) begin
        got = mk(result_kind, slot, fired_tag, total, ok, last);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = expected_results.size();
  end
endmodule

// ===== tb/periodic_alarm_table_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_alarm_table_unit_tb
// Drives tick, add, clear and unused-code commands into the alarm table with random gaps
// and back-pressure; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module periodic_alarm_table_unit_tb;
  import pat_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pat_cmd_if requests ();
  pat_res_if results ();

  periodic_alarm_table_unit dut (.clk(clk), .rst(rst), .requests(requests),
                                 .results(results));

  int fail_count;
  int pending;

  pat_alarm_checker checker_i (
    .clk(clk), .rst(rst),
    .cmd_valid(requests.valid), .cmd_ready(requests.ready), .cmd(requests.cmd),
    .now(requests.now), .offset_in_day(requests.offset_in_day),
    .alarm_kind(requests.alarm_kind), .repeat_count(requests.repeat_count),
    .period(requests.period), .tag(requests.tag),
    .res_valid(results.valid), .res_ready(results.ready),
    .result_kind(results.result_kind), .slot(results.slot),
    .fired_tag(results.fired_tag), .total(results.total), .ok(results.ok),
    .last(results.last), .fail_count(fail_count), .pending(pending));

  // Simulated clock of the alarm world. Ticks mostly advance it a little so
  // that alarms fire again and again; sometimes it jumps to far values.
  logic [31:0] world_time;
  logic        hold_long;
  logic        stim_done;

  initial begin
    requests.valid = 1'b0;
    requests.cmd = CMD_TICK;
    requests.now = '0;
    requests.offset_in_day = '0;
    requests.alarm_kind = '0;
    requests.repeat_count = '0;
    requests.period = '0;
    requests.tag = '0;
    results.ready = 1'b0;
    hold_long = 1'b0;
    stim_done = 1'b0;
  end

  // Offer one transaction and hold it until the block accepts it, then maybe
  // drop valid for a random gap. Valid stays high between back-to-back items.
  task automatic send(input logic [1:0] c, input logic [31:0] t, input logic [16:0] o,
                      input logic [7:0] k, input logic [15:0] r, input logic [31:0] p,
                      input logic [7:0] g);
    int gap;
    requests.valid <= 1'b1;
    requests.cmd <= c;
    requests.now <= t;
    requests.offset_in_day <= o;
    requests.alarm_kind <= k;
    requests.repeat_count <= r;
    requests.period <= p;
    requests.tag <= g;
    do @(posedge clk); while (!requests.ready);
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) :
          ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (gap > 0) begin
      requests.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_add(input logic [31:0] t, input logic [16:0] o, input logic [7:0] k,
                          input logic [15:0] r, input logic [31:0] p, input logic [7:0] g);
    send(CMD_ADD, t, o, k, r, p, g);
  endtask

  task automatic send_random();
    int pick;
    logic [7:0] k;
    pick = $urandom_range(0, 99);
    k = ($urandom_range(0, 3) == 0) ? 8'($urandom) : KIND_FIRING;
    if (pick < 45) begin
      // Mostly near-term alarms with small periods so they keep firing.
      send_add(world_time, ($urandom_range(0, 9) == 0) ? 17'($urandom) :
               17'($urandom_range(0, 86399)), k,
               ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5)),
               ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 50000),
               8'($urandom_range(0, 7)));
    end else if (pick < 85) begin
      world_time = ($urandom_range(0, 19) == 0) ? $urandom :
                   world_time + $urandom_range(0, 40000);
      send(CMD_TICK, world_time, 17'($urandom), 8'($urandom), 16'($urandom), $urandom,
           8'($urandom));
    end else if (pick < 95) begin
      send(CMD_CLEAR, $urandom, 17'($urandom), 8'($urandom), 16'($urandom), $urandom,
           ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)));
    end else begin
      send(2'd3, $urandom, 17'($urandom), 8'($urandom), 16'($urandom), $urandom,
           8'($urandom));
    end
  endtask

  // Receiver: random stalls, plus one long hold-off while commands keep coming.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        results.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_long = 1'b0;
      end
      stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
              ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      if (stall > 0) begin
        results.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results.ready <= 1'b1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    world_time = 32'd100000;

    // Directed part: empty tick, extremes of fields, full table, clears.
    send(CMD_TICK, 32'd0, '0, '0, '0, '0, '0);
    send_add(32'd0, 17'd0, KIND_FIRING, 16'd3, 32'd10, 8'h00);
    send_add(32'hFFFF_FFFF, 17'h1FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    send_add(32'd86400, 17'd86399, KIND_FIRING, 16'hFFFF, 32'hFFFF_FFFF, 8'h5A);
    send_add(32'd200, 17'd0, KIND_FIRING, 16'd0, 32'd1, 8'h11);
    send(CMD_TICK, 32'd1, '0, '0, '0, '0, '0);
    send(CMD_TICK, 32'hFFFF_FFFF, 17'h1FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    send(CMD_TICK, 32'hFFFF_FFFF, '0, '0, '0, '0, '0);
    send(2'd3, 32'hFFFF_FFFF, 17'h1FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    send(CMD_CLEAR, '0, '0, '0, '0, '0, 8'h42);
    send(CMD_CLEAR, '0, '0, '0, '0, '0, 8'hFF);
    // Fill the table past capacity; the long hold-off starts here.
    hold_long = 1'b1;
    for (int i = 0; i < 33; i++)
      send_add(world_time, 17'd0, KIND_FIRING, 16'd2, 32'd5, 8'h77);
    send(CMD_TICK, world_time + 32'd90000, '0, '0, '0, '0, '0);
    send(CMD_CLEAR, '0, '0, '0, '0, '0, 8'h77);
    send(CMD_CLEAR, '0, '0, '0, '0, '0, 8'h00);
    send(CMD_CLEAR, '0, '0, '0, '0, '0, 8'h5A);
    send(CMD_CLEAR, '0, '0, '0, '0, '0, 8'h11);

    for (int n = 0; n < 180; n++) send_random();
    requests.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Watchdog on idle cycles, and the verdict once everything has drained.
  initial begin
    int idle;
    idle = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((requests.valid && requests.ready) || (results.valid && results.ready))
        idle = 0;
      else
        idle++;
      if (idle >= 5000) begin
        $display("Regression FAIL");
        $finish;
      end
      if (stim_done && pending == 0 && !results.valid && idle >= 100) begin
        if (fail_count == 0)
          $display("Regression PASS");
        else
          $display("Regression FAIL");
        $finish;
      end
    end
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/pat_pkg.sv
design/pat_if.sv
design/pat_cell.sv
design/pat_proc.sv
design/periodic_alarm_table_unit.sv
tb/pat_alarm_checker.sv
tb/periodic_alarm_table_unit_tb.sv
